// ===== sv/lgr_pkg.sv =====
// ----------------------------------------------------------------------------
// lgr_pkg: shared types and constants for the linear gain ramp
// Item structs, sequencer states, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lgr_pkg;

	// fixed point: gain is Q4.28 inside, Q4.20 at the ports
	localparam int unsigned GAIN_W     = 32;
	localparam int unsigned PGAIN_W    = 24;
	localparam int unsigned SAMPLE_W   = 24;
	localparam int unsigned RAMP_W     = 20;
	localparam int unsigned STEP_W     = 33;
	localparam int unsigned DIV_STEPS  = 32;
	localparam int unsigned DIV_CNT_W  = 6;
	localparam int unsigned PADDR_W    = 4;

	localparam logic [GAIN_W-1:0]  UNITY_Q428     = 32'h1000_0000;
	localparam logic [PGAIN_W-1:0] GAIN_MIN_RESET = 24'h00_0000;
	localparam logic [PGAIN_W-1:0] GAIN_MAX_RESET = 24'hFF_FFFF;
	localparam logic [RAMP_W-1:0]  RAMP_RESET     = 20'd480;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_GAIN_MIN = 2'd0;
	localparam logic [1:0] REG_GAIN_MAX = 2'd1;
	localparam logic [1:0] REG_RAMP     = 2'd2;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TARGET = 1'b1;

	typedef struct packed {
		logic                       operation;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [PGAIN_W-1:0]         target_gain;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic [PGAIN_W-1:0]         gain_now;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_DIV,
		ST_GAIN,
		ST_MUL,
		ST_OUT
	} lgr_state_t;

endpackage

`default_nettype wire

// ===== sv/lgr_div.sv =====
// ----------------------------------------------------------------------------
// lgr_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, 32-bit dividend over a
// 20-bit divisor. done pulses for one cycle when quotient is final.
// ----------------------------------------------------------------------------
`default_nettype none

module lgr_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [lgr_pkg::GAIN_W-1:0]   dividend,
	input  wire logic [lgr_pkg::RAMP_W-1:0]   divisor,
	output logic                              done,
	output logic [lgr_pkg::GAIN_W-1:0]        quotient
);
	import lgr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] count_q;
	logic [RAMP_W-1:0]    rem_q;
	logic [RAMP_W-1:0]    div_q;
	logic [GAIN_W-1:0]    quo_q;
	logic [RAMP_W:0]      shifted;
	logic [RAMP_W+1:0]    trial;
	logic                 fits;

	always_comb begin
		shifted = {rem_q, quo_q[GAIN_W-1]};
		trial   = {1'b0, shifted} - {2'b00, div_q};
		fits    = ~trial[RAMP_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial[RAMP_W-1:0] : shifted[RAMP_W-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== sv/linear_gain_ramp.sv =====
// ----------------------------------------------------------------------------
// linear_gain_ramp: smoothed linear gain on a 24-bit audio stream
// Set-target items clamp the new gain and work out a per-sample step with a
// serial divider; sample items step the gain, multiply, round and saturate.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   in_data   (in_item_t)
//   out       output     out_valid/out_stall out_data  (out_item_t)
//   config    input      APB psel/penable    paddr/pwdata/prdata
//
// A sample item steps through accept, gain step, multiply and round/saturate.
// A set-target item waits on the bit-serial divider (one quotient bit per
// cycle over 32 bits); a zero ramp length skips the divider.
// One item is in work at a time; in_stall is high until the sequencer idles.
// The output register holds a result until the sink takes it; a stalled
// output holds the sequencer in its last step only.
// Reset loads unity gain, no ramp and the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_gain_ramp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire lgr_pkg::in_item_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output lgr_pkg::out_item_t                out_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lgr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import lgr_pkg::*;

	// configuration
	logic [PGAIN_W-1:0] gain_min_q;
	logic [PGAIN_W-1:0] gain_max_q;
	logic [RAMP_W-1:0]  ramp_q;
	logic               cfg_wr;

	// state
	lgr_state_t         state_q, state_d;
	logic [GAIN_W-1:0]  current_q;
	logic [GAIN_W-1:0]  goal_q;
	logic [STEP_W-1:0]  step_q;
	logic [RAMP_W-1:0]  left_q;

	// item holding
	in_item_t           item_q;
	logic [GAIN_W-1:0]  used_q;
	logic signed [SAMPLE_W+GAIN_W:0] prod_q;
	logic               neg_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// sequencer controls
	logic               in_take;
	logic               div_start;
	logic               out_load;

	// datapath
	logic [PGAIN_W-1:0] clamp_lo, clamp_t;
	logic [GAIN_W-1:0]  goal_new;
	logic [GAIN_W:0]    gain_diff;
	logic [GAIN_W-1:0]  dist_mag;
	logic               div_done;
	logic [GAIN_W-1:0]  div_quo;
	logic [GAIN_W+1:0]  gain_sum;
	logic [GAIN_W-1:0]  gain_step;
	logic signed [SAMPLE_W+GAIN_W+1:0] rnd;
	logic signed [SAMPLE_W+GAIN_W-27:0] qv;
	logic [SAMPLE_W-1:0] sat;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_min_q <= GAIN_MIN_RESET;
			gain_max_q <= GAIN_MAX_RESET;
			ramp_q     <= RAMP_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GAIN_MIN: gain_min_q <= pwdata[PGAIN_W-1:0];
				REG_GAIN_MAX: gain_max_q <= pwdata[PGAIN_W-1:0];
				REG_RAMP:     ramp_q     <= pwdata[RAMP_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GAIN_MIN: prdata = {8'h00, gain_min_q};
			REG_GAIN_MAX: prdata = {8'h00, gain_max_q};
			REG_RAMP:     prdata = {12'h000, ramp_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (in_data.operation == OP_TARGET) ? ST_CLAMP : ST_GAIN;
				end
			end
			ST_CLAMP: begin
				if (ramp_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_GAIN: state_d = ST_MUL;
			ST_MUL:  state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_take = in_valid & ~in_stall;

	// ---------------- arithmetic ----------------
	always_comb begin
		clamp_lo  = (item_q.target_gain < gain_min_q) ? gain_min_q : item_q.target_gain;
		clamp_t   = (clamp_lo > gain_max_q) ? gain_max_q : clamp_lo;
		goal_new  = {clamp_t, 8'h00};
		gain_diff = {1'b0, goal_new} - {1'b0, current_q};
		dist_mag  = gain_diff[GAIN_W] ? GAIN_W'(-gain_diff) : gain_diff[GAIN_W-1:0];

		// step the gain and clamp to the unsigned Q4.28 range
		gain_sum = {2'b00, current_q} + {step_q[STEP_W-1], step_q};
		if (gain_sum[GAIN_W+1]) begin
			gain_step = '0;
		end else if (gain_sum[GAIN_W]) begin
			gain_step = '1;
		end else begin
			gain_step = gain_sum[GAIN_W-1:0];
		end

		// round half up, then saturate to 24 bits
		rnd = {prod_q[SAMPLE_W+GAIN_W], prod_q} + (SAMPLE_W+GAIN_W+2)'(1 << 27);
		qv  = rnd[SAMPLE_W+GAIN_W+1:28];
		if (qv > (SAMPLE_W+GAIN_W-26)'(signed'(8388607))) begin
			sat = 24'h7F_FFFF;
		end else if (qv < -(SAMPLE_W+GAIN_W-26)'(signed'(8388608))) begin
			sat = 24'h80_0000;
		end else begin
			sat = qv[SAMPLE_W-1:0];
		end
	end

	lgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dist_mag),
		.divisor  (ramp_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- gain state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= UNITY_Q428;
			goal_q    <= UNITY_Q428;
			step_q    <= '0;
			left_q    <= '0;
		end else begin
			case (state_q)
				ST_CLAMP: begin
					goal_q <= goal_new;
					if (ramp_q == '0) begin
						current_q <= goal_new;
						step_q    <= '0;
						left_q    <= '0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						step_q <= neg_q ? -{1'b0, div_quo} : {1'b0, div_quo};
						left_q <= ramp_q;
					end
				end
				ST_GAIN: begin
					if (left_q != '0) begin
						left_q    <= left_q - 1'b1;
						// snap on the last ramp sample
						current_q <= (left_q == RAMP_W'(1)) ? goal_q : gain_step;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- item payload ----------------
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q <= in_data;
		end
		if (state_q == ST_CLAMP) begin
			neg_q <= gain_diff[GAIN_W];
		end
		if (state_q == ST_GAIN) begin
			used_q <= (left_q != '0) ? gain_step : current_q;
		end
		if (state_q == ST_MUL) begin
			prod_q <= item_q.sample_in * $signed({1'b0, used_q});
		end
		if (out_load) begin
			out_q.sample_out <= sat;
			out_q.gain_now   <= current_q[GAIN_W-1:8];
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== sv/lgr_chk.sv =====
// ----------------------------------------------------------------------------
// lgr_chk: port-level checks for the linear gain ramp
// Watches the handshakes and the item flow; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lgr_chk (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire lgr_pkg::in_item_t            in_data,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire lgr_pkg::out_item_t           out_data,
	input  wire logic                         pready
);
	import lgr_pkg::*;

	logic in_xfer;
	assign in_xfer = in_valid & ~in_stall;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output changed");

	// one item in work at a time
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while an item is in work");

	// a set-target transfer never makes a result
	a_target_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && in_data.operation == OP_TARGET && !out_valid |=> !out_valid)
		else $error("result from a set-target transfer");

	// a sample taken while the output is empty makes a result
	a_sample_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && in_data.operation == OP_SAMPLE && !out_valid |-> ##4 out_valid)
		else $error("sample result missing");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind linear_gain_ramp lgr_chk u_lgr_chk (.*);

`default_nettype wire

// ===== tb/linear_gain_ramp_test.sv =====
// ----------------------------------------------------------------------------
// linear_gain_ramp_test: self-checking bench for the linear gain ramp
// Drives a table of directed transfers, then randomized phases under several
// register settings, with bursty input and a stalling sink. A tracking model
// of the gain ramp predicts each result the table does not give; results are compared per field.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_gain_ramp_test;

	import lgr_pkg::*;

	localparam int     CLK_PERIOD    = 4;
	localparam int     RESET_CYCLES  = 10;
	localparam int     SETTLE_CYCLES = 64;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     RANDOM_ITEMS  = 1850;
	localparam int     PHASES        = 12;
	localparam int     REPORT_CAP    = 20;
	localparam longint LIMIT_CYCLES  = 800000;
	localparam longint GAIN_CEIL     = 64'h0000_0000_FFFF_FFFF;

	// address slot past the last register, writes to it must be ignored
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [23:0] reg_value;
		logic        op;
		logic [23:0] sample;
		logic [23:0] target;
		bit          typed;
		logic [23:0] want_out;
		logic [23:0] want_gain;
	} plan_row_t;

	localparam int PLAN_ROWS = 35;

	localparam plan_row_t DIRECTED_PLAN [0:PLAN_ROWS-1] = '{
		// unity gain straight out of reset
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h000000, 24'hFFFFFF, 1'b1, 24'h000000, 24'h100000},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h7FFFFF, 24'h000000, 1'b1, 24'h7FFFFF, 24'h100000},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h800000, 24'h5A5A5A, 1'b1, 24'h800000, 24'h100000},
		// zero ramp length: jump at once, saturate at top gain, mute at zero
		'{ROW_WRITE, REG_RAMP, 24'h000000, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'hA5A5A5, 24'hFFFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h7FFFFF, 24'hA5A5A5, 1'b1, 24'h7FFFFF, 24'hFFFFFF},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h800000, 24'h5A5A5A, 1'b1, 24'h800000, 24'hFFFFFF},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'h5A5A5A, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 24'h000000, 24'h000000},
		// floor above ceiling: ceiling wins, then rounding ties at half gain
		'{ROW_WRITE, REG_GAIN_MIN, 24'h200000, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, REG_GAIN_MAX, 24'h080000, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'h000000, 24'h300000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h400000, 24'h000000, 1'b1, 24'h200000, 24'h080000},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h000001, 24'h000000, 1'b1, 24'h000001, 24'h080000},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'hFFFFFF, 24'h000000, 1'b1, 24'h000000, 24'h080000},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'hFFFFFF, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h7FFFFF, 24'h000000, 1'b1, 24'h400000, 24'h080000},
		// short ramp, restarted after its first sample, ending in the snap to target
		'{ROW_WRITE, REG_GAIN_MIN, 24'h000000, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, REG_GAIN_MAX, 24'hFFFFFF, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, REG_RAMP, 24'h000004, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'h000000, 24'h200000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h123456, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'h000000, 24'h0C0000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h654321, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h7FFFFF, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h3C3C3C, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'hC3C3C3, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, REG_SPARE, 24'h000001, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h0F0F0F, 24'h000000, 1'b0, 24'h0, 24'h0},
		// one-sample ramp, then the longest ramp
		'{ROW_WRITE, REG_RAMP, 24'h000001, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'h000000, 24'h0A0000, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'hF0F0F0, 24'h000000, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, REG_RAMP, 24'h0FFFFF, OP_SAMPLE, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_TARGET, 24'h000000, 24'hFFFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_ITEM,  REG_RAMP, 24'h0, OP_SAMPLE, 24'h7FFFFF, 24'h000000, 1'b0, 24'h0, 24'h0}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [31:0]         pwdata    = '0;
	logic [31:0]         prdata;
	logic                pready;

	// tracked copy of the block's registers and ramp state
	logic [PGAIN_W-1:0]  cfg_floor = GAIN_MIN_RESET;
	logic [PGAIN_W-1:0]  cfg_ceil  = GAIN_MAX_RESET;
	logic [RAMP_W-1:0]   cfg_len   = RAMP_RESET;
	logic [GAIN_W-1:0]   ramp_gain = UNITY_Q428;
	logic [GAIN_W-1:0]   ramp_goal = UNITY_Q428;
	longint              ramp_step = 0;
	logic [RAMP_W-1:0]   ramp_left = '0;

	out_item_t           pending_out [$];
	int                  burst_left     = 0;
	int                  mismatches     = 0;
	int                  results_seen   = 0;
	int                  transfers_in   = 0;
	int                  targets_in     = 0;
	int                  reg_writes     = 0;
	bit                  squeeze_req    = 1'b0;

	linear_gain_ramp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Q1.23 sample times Q4.28 gain, round half up, saturate to 24 bits
	function automatic logic [SAMPLE_W-1:0] scale_sample(logic signed [SAMPLE_W-1:0] s,
			logic [GAIN_W-1:0] g);
		longint prod;
		longint q;
		prod = longint'(s) * longint'(g);
		q = (prod + 64'sd134217728) >>> 28;
		if (q > 8388607)
			q = 8388607;
		else if (q < -8388608)
			q = -8388608;
		return q[SAMPLE_W-1:0];
	endfunction

	task automatic track_gain(input in_item_t it, output bit made, output out_item_t res);
		logic [PGAIN_W-1:0] t;
		logic [GAIN_W-1:0]  used;
		longint             g;
		res = '0;
		made = 1'b0;
		if (it.operation == OP_TARGET) begin
			t = it.target_gain;
			if (t < cfg_floor)
				t = cfg_floor;
			if (t > cfg_ceil)
				t = cfg_ceil;
			ramp_goal = {t, 8'h00};
			if (cfg_len == 0) begin
				ramp_gain = ramp_goal;
				ramp_step = 0;
				ramp_left = '0;
			end else begin
				ramp_step = (longint'(ramp_goal) - longint'(ramp_gain)) / longint'(cfg_len);
				ramp_left = cfg_len;
			end
		end else begin
			used = ramp_gain;
			if (ramp_left != 0) begin
				g = longint'(ramp_gain) + ramp_step;
				if (g < 0)
					g = 0;
				else if (g > GAIN_CEIL)
					g = GAIN_CEIL;
				used = g[GAIN_W-1:0];
				ramp_gain = used;
				ramp_left = ramp_left - 1'b1;
				// snap onto the target with the last ramp sample
				if (ramp_left == 0)
					ramp_gain = ramp_goal;
			end
			res.sample_out = scale_sample(it.sample_in, used);
			res.gain_now = ramp_gain[GAIN_W-1:8];
			made = 1'b1;
		end
	endtask

	// enter at a falling edge, leave at a falling edge after the transfer and any idle gap
	task automatic offer_transfer(input in_item_t it, input bit typed, input out_item_t want);
		bit        made;
		out_item_t res;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		track_gain(it, made, res);
		transfers_in++;
		if (it.operation == OP_TARGET)
			targets_in++;
		if (typed)
			pending_out.push_back(want);
		else if (made)
			pending_out.push_back(res);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 250)
				: $urandom_range(0, 12);
		end
	endtask

	// let every result out, then give a set-target item time to finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_out.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_reg(input logic [1:0] idx, input logic [23:0] val, input bit noisy);
		logic [31:0] junk;
		logic [31:0] word;
		junk = $urandom;
		word = noisy ? {junk[31:24], val} : {8'h00, val};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAIN_MIN: cfg_floor = word[PGAIN_W-1:0];
			REG_GAIN_MAX: cfg_ceil = word[PGAIN_W-1:0];
			REG_RAMP:     cfg_len = word[RAMP_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	initial begin : stimulus
		plan_row_t          row;
		in_item_t           it;
		out_item_t          want;
		logic [PGAIN_W-1:0] lo;
		logic [PGAIN_W-1:0] hi;
		logic [RAMP_W-1:0]  len;
		int                 per_phase;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			row = DIRECTED_PLAN[r];
			if (row.kind == ROW_WRITE) begin
				wait_idle();
				program_reg(row.reg_idx, row.reg_value, 1'b0);
			end else begin
				it.operation = row.op;
				it.sample_in = row.sample;
				it.target_gain = row.target;
				want.sample_out = row.want_out;
				want.gain_now = row.want_gain;
				offer_transfer(it, row.typed, want);
			end
		end

		per_phase = RANDOM_ITEMS / PHASES;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					lo = 24'h000000;
					hi = 24'hFFFFFF;
					len = '0;
				end
				1: begin
					lo = 24'h000000;
					hi = 24'hFFFFFF;
					len = 20'hFFFFF;
				end
				2: begin
					lo = PGAIN_W'($urandom);
					hi = lo;
					len = RAMP_W'($urandom_range(1, 8));
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						lo = PGAIN_W'($urandom);
						hi = PGAIN_W'($urandom);
					end else begin
						lo = PGAIN_W'($urandom_range(0, 24'h200000));
						hi = PGAIN_W'($urandom_range(24'h100000, 24'hFFFFFF));
					end
					case ($urandom_range(0, 9))
						0: len = '0;
						1: len = 20'd1;
						2: len = RAMP_W'($urandom);
						default: len = RAMP_W'($urandom_range(2, 48));
					endcase
				end
			endcase
			wait_idle();
			program_reg(REG_GAIN_MIN, lo, 1'b1);
			program_reg(REG_GAIN_MAX, hi, 1'b1);
			program_reg(REG_RAMP, {4'h0, len}, 1'b1);
			// long sink hold-off while the source keeps pushing
			if (phase == 4)
				squeeze_req = 1'b1;
			for (int n = 0; n < per_phase; n++) begin
				it.sample_in = SAMPLE_W'($urandom);
				it.target_gain = PGAIN_W'($urandom);
				if ($urandom_range(0, 99) < 8) begin
					it.operation = OP_TARGET;
					case ($urandom_range(0, 7))
						0: it.target_gain = 24'h000000;
						1: it.target_gain = 24'hFFFFFF;
						2: it.target_gain = cfg_floor;
						3: it.target_gain = cfg_ceil;
						default: ;
					endcase
				end else begin
					it.operation = OP_SAMPLE;
					case ($urandom_range(0, 15))
						0: it.sample_in = 24'h7FFFFF;
						1: it.sample_in = 24'h800000;
						2: it.sample_in = 24'h000000;
						default: ;
					endcase
				end
				offer_transfer(it, 1'b0, want);
			end
		end

		wait_idle();
		$display("run covered %0d transfers in (%0d set-target), %0d results checked,",
			transfers_in, targets_in, results_seen);
		$display("  %0d register writes over %0d random phases plus the directed table",
			reg_writes, PHASES);
		if (mismatches == 0 && pending_out.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : sink_pattern
		int seg;
		int pct;
		bit squeezed;
		squeezed = 1'b0;
		@(posedge arst_n);
		forever begin
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				seg = $urandom_range(16, 160);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 20;
					2: pct = 50;
					default: pct = 85;
				endcase
				for (int k = 0; k < seg; k++) begin
					@(negedge clk);
					out_stall <= ($urandom_range(0, 99) < pct);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_out.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: result with nothing expected: sample_out %h gain_now %h",
						$time, out_data.sample_out, out_data.gain_now);
			end else begin
				want = pending_out.pop_front();
				results_seen++;
				if (out_data.sample_out !== want.sample_out) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: sample_out expected %h got %h",
							$time, want.sample_out, out_data.sample_out);
				end
				if (out_data.gain_now !== want.gain_now) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: gain_now expected %h got %h",
							$time, want.gain_now, out_data.gain_now);
				end
			end
		end
	end

	initial begin : watchdog
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results still pending", pending_out.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
